/* design/ffba_pkg.sv */
// shared types, constants and state codes for the first-fit block allocator
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    localparam int NUM_BLOCKS_DEF = 256;

    // occupancy map row: blocks handled per map access
    localparam int WORD_W     = 8;
    localparam int WORD_IDX_W = 3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [1:0] STATUS_BAD    = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [8:0] block_count;
        logic [7:0] first_block;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] slot_index;
        logic [8:0] free_blocks;
    } resp_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } map_ctl_t;

    typedef struct packed {
        logic                  found;
        logic [WORD_IDX_W-1:0] end_bit;
    } scan_hit_t;

    typedef enum logic [3:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_SCAN_RD,
        SEQ_SCAN_EV,
        SEQ_FIT,
        SEQ_CHK_RD,
        SEQ_CHK_EV,
        SEQ_MARK_RD,
        SEQ_MARK_WR,
        SEQ_RESP
    } seq_state_t;

endpackage

`default_nettype wire

/* design/ffba_map_mem.sv */
// occupancy map memory, one row of blocks per entry, registered read
`timescale 1ns / 1ps
`default_nettype none

module ffba_map_mem #(
    parameter int ROWS  = 32,
    parameter int ROW_W = 5
) (
    input  wire                                clk,
    input  wire ffba_pkg::map_ctl_t            ctl,
    input  wire  [ROW_W-1:0]                   addr,
    input  wire  [ffba_pkg::WORD_W-1:0]        wdata,
    output logic [ffba_pkg::WORD_W-1:0]        rdata
);

    logic [ffba_pkg::WORD_W-1:0] mem [ROWS];
    logic [ffba_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/ffba_row_scan.sv */
// free-run counter over one map row, stops where the run reaches the length
`timescale 1ns / 1ps
`default_nettype none

module ffba_row_scan #(
    parameter int CNT_W = 9
) (
    input  wire  [ffba_pkg::WORD_W-1:0] row_data,
    input  wire  [CNT_W-1:0]            run_in,
    input  wire  [CNT_W-1:0]            len,
    output logic [CNT_W-1:0]            run_out,
    output ffba_pkg::scan_hit_t         hit
);

    always_comb
    begin
        logic [CNT_W-1:0] run;
        logic             found;
        logic [ffba_pkg::WORD_IDX_W-1:0] end_bit;
        run     = run_in;
        found   = 1'b0;
        end_bit = '0;
        for (int b = 0; b < ffba_pkg::WORD_W; b++)
        begin
            if (!found)
            begin
                if (row_data[b])
                begin
                    run = '0;
                end
                else
                begin
                    run = run + CNT_W'(1);
                    if (run == len)
                    begin
                        found   = 1'b1;
                        end_bit = ffba_pkg::WORD_IDX_W'(b);
                    end
                end
            end
        end
        run_out     = run;
        hit.found   = found;
        hit.end_bit = end_bit;
    end

endmodule

`default_nettype wire

/* design/ffba_seq.sv */
// request sequencer: validation, first-fit scan, range check and map update
`timescale 1ns / 1ps
`default_nettype none

module ffba_seq #(
    parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    output logic                         req_stall,
    input  wire  ffba_pkg::req_t         req,
    output logic                         resp_valid,
    input  wire                          resp_ready,
    output ffba_pkg::resp_t              resp
);

    localparam int ROWS  = (NUM_BLOCKS + ffba_pkg::WORD_W - 1) / ffba_pkg::WORD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W = ROW_W + ffba_pkg::WORD_IDX_W;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int WW    = ffba_pkg::WORD_W;
    localparam int WIW   = ffba_pkg::WORD_IDX_W;

    ffba_pkg::seq_state_t state_reg, state_next;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;
    logic [POS_W-1:0] s_reg, s_next;
    logic [POS_W-1:0] e_reg, e_next;
    logic             op_reg, op_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       slot_reg, slot_next;

    ffba_pkg::map_ctl_t mem_ctl;
    logic [WW-1:0]      mem_wdata;
    logic [WW-1:0]      mem_rdata;
    logic [WW-1:0]      range_mask;
    logic [WW-1:0]      pad_bits;
    logic [CNT_W-1:0]   scan_run;
    ffba_pkg::scan_hit_t scan_hit;

    logic               req_fire;
    logic               len_bad;
    logic               free_oob;
    logic [9:0]         free_end;
    logic               last_row;
    logic               at_end_row;
    logic [POS_W-1:0]   free_s;
    logic [POS_W-1:0]   fit_s;

    ffba_map_mem #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_map (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (row_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    ffba_row_scan #(
        .CNT_W (CNT_W)
    ) u_scan (
        .row_data (mem_rdata),
        .run_in   (run_reg),
        .len      (len_reg),
        .run_out  (scan_run),
        .hit      (scan_hit)
    );

    assign req_fire   = req_valid && (state_reg == ffba_pkg::SEQ_IDLE);
    assign len_bad    = (req.block_count == 9'd0) || (32'(req.block_count) > NUM_BLOCKS);
    assign free_end   = 10'(req.first_block) + 10'(req.block_count);
    assign free_oob   = 32'(free_end) > NUM_BLOCKS;
    assign last_row   = (row_reg == ROW_W'(ROWS - 1));
    assign at_end_row = (row_reg == e_reg[POS_W-1 -: ROW_W]);
    assign free_s     = POS_W'(req.first_block);
    assign fit_s      = e_reg + POS_W'(1) - POS_W'(len_reg);

    // blocks of the current row that fall inside [s, e], and padding past the pool
    always_comb
    begin
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int b = 0; b < WW; b++)
        begin
            pos           = {row_reg, WIW'(b)};
            range_mask[b] = (pos >= s_reg) && (pos <= e_reg);
            pad_bits[b]   = 32'(pos) >= NUM_BLOCKS;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::SEQ_CLEAR:
            begin
                if (last_row)
                begin
                    state_next = ffba_pkg::SEQ_IDLE;
                end
            end
            ffba_pkg::SEQ_IDLE:
            begin
                if (req_valid)
                begin
                    if (len_bad || (req.req_type == ffba_pkg::REQ_FREE && free_oob))
                    begin
                        state_next = ffba_pkg::SEQ_RESP;
                    end
                    else if (req.req_type == ffba_pkg::REQ_ALLOC)
                    begin
                        state_next = ffba_pkg::SEQ_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ffba_pkg::SEQ_CHK_RD;
                    end
                end
            end
            ffba_pkg::SEQ_SCAN_RD: state_next = ffba_pkg::SEQ_SCAN_EV;
            ffba_pkg::SEQ_SCAN_EV:
            begin
                if (scan_hit.found)
                begin
                    state_next = ffba_pkg::SEQ_FIT;
                end
                else if (last_row)
                begin
                    state_next = ffba_pkg::SEQ_RESP;
                end
                else
                begin
                    state_next = ffba_pkg::SEQ_SCAN_RD;
                end
            end
            ffba_pkg::SEQ_FIT:     state_next = ffba_pkg::SEQ_MARK_RD;
            ffba_pkg::SEQ_CHK_RD:  state_next = ffba_pkg::SEQ_CHK_EV;
            ffba_pkg::SEQ_CHK_EV:
            begin
                if ((mem_rdata & range_mask) != range_mask)
                begin
                    state_next = ffba_pkg::SEQ_RESP;
                end
                else if (at_end_row)
                begin
                    state_next = ffba_pkg::SEQ_MARK_RD;
                end
                else
                begin
                    state_next = ffba_pkg::SEQ_CHK_RD;
                end
            end
            ffba_pkg::SEQ_MARK_RD: state_next = ffba_pkg::SEQ_MARK_WR;
            ffba_pkg::SEQ_MARK_WR:
            begin
                if (at_end_row)
                begin
                    state_next = ffba_pkg::SEQ_RESP;
                end
                else
                begin
                    state_next = ffba_pkg::SEQ_MARK_RD;
                end
            end
            ffba_pkg::SEQ_RESP:
            begin
                if (resp_ready)
                begin
                    state_next = ffba_pkg::SEQ_IDLE;
                end
            end
            default: state_next = ffba_pkg::SEQ_CLEAR;
        endcase
    end

    // outputs and map access
    always_comb
    begin
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_wdata     = mem_rdata | range_mask;
        req_stall     = 1'b1;
        resp_valid    = 1'b0;
        case (state_reg)
            ffba_pkg::SEQ_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_wdata     = pad_bits;
            end
            ffba_pkg::SEQ_IDLE:    req_stall     = 1'b0;
            ffba_pkg::SEQ_SCAN_RD: mem_ctl.rd_en = 1'b1;
            ffba_pkg::SEQ_CHK_RD:  mem_ctl.rd_en = 1'b1;
            ffba_pkg::SEQ_MARK_RD: mem_ctl.rd_en = 1'b1;
            ffba_pkg::SEQ_MARK_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                if (op_reg == ffba_pkg::REQ_FREE)
                begin
                    mem_wdata = mem_rdata & ~range_mask;
                end
            end
            ffba_pkg::SEQ_RESP:    resp_valid    = 1'b1;
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        row_next      = row_reg;
        run_next      = run_reg;
        len_next      = len_reg;
        free_cnt_next = free_cnt_reg;
        s_next        = s_reg;
        e_next        = e_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        case (state_reg)
            ffba_pkg::SEQ_CLEAR:
            begin
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            ffba_pkg::SEQ_IDLE:
            begin
                if (req_fire)
                begin
                    op_next     = req.req_type;
                    len_next    = CNT_W'(req.block_count);
                    run_next    = '0;
                    status_next = ffba_pkg::STATUS_BAD;
                    slot_next   = 8'd0;
                    if (req.req_type == ffba_pkg::REQ_ALLOC)
                    begin
                        row_next = '0;
                    end
                    else
                    begin
                        s_next   = free_s;
                        e_next   = free_s + POS_W'(req.block_count) - POS_W'(1);
                        row_next = free_s[POS_W-1 -: ROW_W];
                    end
                end
            end
            ffba_pkg::SEQ_SCAN_EV:
            begin
                run_next = scan_run;
                if (scan_hit.found)
                begin
                    e_next = {row_reg, scan_hit.end_bit};
                end
                else if (last_row)
                begin
                    status_next = ffba_pkg::STATUS_NO_FIT;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ffba_pkg::SEQ_FIT:
            begin
                s_next   = fit_s;
                row_next = fit_s[POS_W-1 -: ROW_W];
            end
            ffba_pkg::SEQ_CHK_EV:
            begin
                if (at_end_row)
                begin
                    row_next = s_reg[POS_W-1 -: ROW_W];
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ffba_pkg::SEQ_MARK_WR:
            begin
                if (at_end_row)
                begin
                    status_next = ffba_pkg::STATUS_OK;
                    if (op_reg == ffba_pkg::REQ_ALLOC)
                    begin
                        free_cnt_next = free_cnt_reg - len_reg;
                        slot_next     = 8'(s_reg);
                    end
                    else
                    begin
                        free_cnt_next = free_cnt_reg + len_reg;
                    end
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffba_pkg::SEQ_CLEAR;
            row_reg      <= '0;
            free_cnt_reg <= CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            free_cnt_reg <= free_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg    <= run_next;
        len_reg    <= len_next;
        s_reg      <= s_next;
        e_reg      <= e_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    assign resp.status      = status_reg;
    assign resp.slot_index  = slot_reg;
    assign resp.free_blocks = 9'(free_cnt_reg);

endmodule

`default_nettype wire

/* design/first_fit_block_allocator.sv */
// top level of the first-fit contiguous block allocator with output register
`timescale 1ns / 1ps
`default_nettype none

// Keeps NUM_BLOCKS blocks as a one-bit-per-block occupancy map held in a
// single-port memory of 8-block rows. Allocate finds the lowest free run of
// block_count blocks and marks it used; free checks that the whole range is
// in use, then releases it, so neighboring free space joins up by itself.
// Every request gives one reply with status, slot_index and free_blocks.
// One item at a time: in_stall is high from acceptance until the reply is
// written into the output register. Each map row takes a read state, then
// an evaluate or write-back state, through the one memory port. An allocate
// scans rows until one completes the run (or all ceil(NUM_BLOCKS/8) rows
// when nothing fits), then takes a fit step, marks each row of the run and
// gives the reply. A free checks each row of the range and, if all are in
// use, releases each row, then gives the reply. A bad request goes straight
// to the reply. After reset a clearing pass writes ceil(NUM_BLOCKS/8) rows,
// one per cycle, with in_stall held high.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire  ffba_pkg::req_t  in_data,
    output logic                  out_valid,
    input  wire                   out_stall,
    output ffba_pkg::resp_t       out_data
);

    logic            resp_valid;
    logic            resp_ready;
    ffba_pkg::resp_t resp;

    logic            out_valid_reg, out_valid_next;
    ffba_pkg::resp_t out_data_reg;

    ffba_seq #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_valid),
        .req_stall  (in_stall),
        .req        (in_data),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    // the reply slot is free when empty or when its transaction completes now
    assign resp_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (resp_valid && resp_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_valid && resp_ready)
        begin
            out_data_reg <= resp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* test/testbench.sv */
// self-checking testbench for the first-fit block allocator
`timescale 1ns / 1ps

module testbench;

    localparam int POOL_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 150;
    localparam int REQ_W        = $bits(ffba_pkg::req_t);

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    ffba_pkg::req_t  in_data   = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    ffba_pkg::resp_t out_data;

    // predicted pool state, updated as each transaction is accepted
    bit              block_taken [POOL_BLOCKS];
    int              blocks_free = POOL_BLOCKS;
    ffba_pkg::resp_t expected_replies [$];
    int              mismatches = 0;
    bit              no_idle = 1'b0;
    int              stall_run = 0;

    first_fit_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH: %s", what);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic int pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 8);
        else if (roll < 90)
            return $urandom_range(9, 40);
        else if (roll < 98)
            return $urandom_range(41, 128);
        return $urandom_range(129, POOL_BLOCKS);
    endfunction

    function automatic int used_run_from(input int blk);
        int n;
        n = 0;
        while (blk + n < POOL_BLOCKS && block_taken[blk + n])
            n++;
        return n;
    endfunction

    // first-fit search over the occupancy map, then mark or release
    function automatic ffba_pkg::resp_t allocator_reply(input ffba_pkg::req_t r);
        ffba_pkg::resp_t rsp;
        int    run;
        int    base;
        int    len;
        int    start_blk;
        bit    clash;
        rsp       = '0;
        len       = int'(r.block_count);
        start_blk = int'(r.first_block);
        base      = -1;
        if (len == 0 || len > POOL_BLOCKS)
            rsp.status = ffba_pkg::STATUS_BAD;
        else if (r.req_type == ffba_pkg::REQ_ALLOC)
        begin
            run = 0;
            for (int i = 0; i < POOL_BLOCKS && base < 0; i++)
            begin
                run = block_taken[i] ? 0 : run + 1;
                if (run >= len)
                    base = i + 1 - len;
            end
            if (base < 0)
                rsp.status = ffba_pkg::STATUS_NO_FIT;
            else
            begin
                for (int i = base; i < base + len; i++)
                    block_taken[i] = 1'b1;
                blocks_free -= len;
                rsp.status     = ffba_pkg::STATUS_OK;
                rsp.slot_index = base[7:0];
            end
        end
        else if (start_blk + len > POOL_BLOCKS)
            rsp.status = ffba_pkg::STATUS_BAD;
        else
        begin
            clash = 1'b0;
            for (int i = start_blk; i < start_blk + len; i++)
                if (!block_taken[i])
                    clash = 1'b1;
            if (clash)
                rsp.status = ffba_pkg::STATUS_BAD;
            else
            begin
                for (int i = start_blk; i < start_blk + len; i++)
                    block_taken[i] = 1'b0;
                blocks_free += len;
                rsp.status = ffba_pkg::STATUS_OK;
            end
        end
        rsp.free_blocks = blocks_free[8:0];
        return rsp;
    endfunction

    task automatic issue_request(input logic kind, input int len, input int start_blk);
        ffba_pkg::req_t    r;
        logic [REQ_W-1:0]  junk;
        int                gap;
        r.req_type    = kind;
        r.block_count = len[8:0];
        r.first_block = start_blk[7:0];
        gap  = pick_gap();
        junk = REQ_W'($urandom);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            in_data  <= junk;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        expected_replies.push_back(allocator_reply(r));
    endtask

    // frees the lowest used run until the pool is empty again
    task automatic release_all();
        int blk;
        while (blocks_free < POOL_BLOCKS)
        begin
            blk = 0;
            while (!block_taken[blk])
                blk++;
            issue_request(ffba_pkg::REQ_FREE, used_run_from(blk), blk);
        end
    endtask

    // mostly legal allocate/free traffic, some raw noise
    task automatic random_request();
        int roll;
        int blk;
        int len;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            issue_request(1'($urandom_range(0, 1)), $urandom_range(0, 511),
                          $urandom_range(0, 255));
        else if (roll < 55 || blocks_free == POOL_BLOCKS)
            issue_request(ffba_pkg::REQ_ALLOC, pick_len(), $urandom_range(0, 255));
        else
        begin
            blk = $urandom_range(0, POOL_BLOCKS - 1);
            while (!block_taken[blk])
                blk = (blk + 1) % POOL_BLOCKS;
            len = used_run_from(blk);
            if ($urandom_range(0, 1))
                len = $urandom_range(1, len);
            issue_request(ffba_pkg::REQ_FREE, len, blk);
        end
    endtask

    task automatic test_edge_cases();
        issue_request(ffba_pkg::REQ_ALLOC, 0, 0);
        issue_request(ffba_pkg::REQ_ALLOC, 257, 255);
        issue_request(ffba_pkg::REQ_ALLOC, 511, 170);
        issue_request(ffba_pkg::REQ_FREE, 0, 85);
        issue_request(ffba_pkg::REQ_FREE, 300, 0);
        issue_request(ffba_pkg::REQ_FREE, 1, 0);          // never allocated
        issue_request(ffba_pkg::REQ_ALLOC, 256, 85);      // whole pool
        issue_request(ffba_pkg::REQ_ALLOC, 1, 0);         // nothing left
        issue_request(ffba_pkg::REQ_FREE, 100, 200);      // runs past the end
        issue_request(ffba_pkg::REQ_FREE, 1, 255);
        issue_request(ffba_pkg::REQ_FREE, 1, 255);        // double free
        issue_request(ffba_pkg::REQ_ALLOC, 2, 0);
        issue_request(ffba_pkg::REQ_ALLOC, 1, 0);         // lands on the last block
        issue_request(ffba_pkg::REQ_FREE, 256, 0);
        issue_request(ffba_pkg::REQ_ALLOC, 10, 0);
        issue_request(ffba_pkg::REQ_ALLOC, 20, 0);
        issue_request(ffba_pkg::REQ_ALLOC, 5, 0);
        issue_request(ffba_pkg::REQ_FREE, 20, 10);
        issue_request(ffba_pkg::REQ_ALLOC, 25, 0);        // hole too small, skips ahead
        issue_request(ffba_pkg::REQ_FREE, 10, 0);
        issue_request(ffba_pkg::REQ_ALLOC, 30, 0);        // joined hole now fits
        issue_request(ffba_pkg::REQ_FREE, 5, 30);
        release_all();
    endtask

    task automatic test_full_pool();
        repeat (16)
            issue_request(ffba_pkg::REQ_ALLOC, 16, $urandom_range(0, 255));
        issue_request(ffba_pkg::REQ_ALLOC, 1, 0);
        for (int k = 1; k < 16; k += 2)
            issue_request(ffba_pkg::REQ_FREE, 16, 16 * k);
        issue_request(ffba_pkg::REQ_ALLOC, 17, 0);
        issue_request(ffba_pkg::REQ_ALLOC, 16, 0);
        issue_request(ffba_pkg::REQ_FREE, 16, 32);
        issue_request(ffba_pkg::REQ_ALLOC, 32, 0);
        issue_request(ffba_pkg::REQ_ALLOC, 48, 0);
        release_all();
    endtask

    task automatic test_random_traffic();
        repeat (440)
            random_request();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (60)
            random_request();
        no_idle = 1'b0;
    endtask

    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (no_idle || stall_run == 0)
        begin
            out_stall <= 1'b0;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_run <= pick_gap();
        end
        else
        begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
    end

    always @(posedge clk)
    begin : reply_check
        ffba_pkg::resp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
                report_mismatch($sformatf("unexpected reply status=%0d slot=%0d free=%0d",
                    out_data.status, out_data.slot_index, out_data.free_blocks));
            else
            begin
                want = expected_replies.pop_front();
                if (out_data.status !== want.status
                    || out_data.slot_index !== want.slot_index
                    || out_data.free_blocks !== want.free_blocks)
                    report_mismatch($sformatf(
                        "status %0d exp %0d, slot %0d exp %0d, free %0d exp %0d",
                        out_data.status, want.status, out_data.slot_index,
                        want.slot_index, out_data.free_blocks, want.free_blocks));
            end
        end
    end

    // no transaction on either side for too long means the block is hung
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_edge_cases();
        test_full_pool();
        test_random_traffic();
        test_back_to_back();
        drain_replies();
        if (expected_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
